>>> hw/rtl/nic_pkg.sv
// Shared types and constants for the nonzero index compactor.
`default_nettype none

package nic_pkg;

    localparam int MAX_DIMS_DEF    = 4;
    localparam int INDEX_WIDTH_DEF = 16;

    localparam int NUM_SIZE_REGS = 4;   // extent registers dim_size_0..3
    localparam int OUT_INDEX     = 4;   // index ports index_0..3
    localparam int DIM_W         = 16;  // extent and reported index width
    localparam int ND_W          = 3;   // num_dims register width
    localparam int COUNT_W       = 32;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 5;
    localparam int REG_IDX_W     = 3;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

    typedef struct packed {
        logic [ND_W-1:0]                     num_dims;
        logic [NUM_SIZE_REGS-1:0][DIM_W-1:0] dim_size;
    } cfg_t;

    typedef struct packed {
        logic                            emit;
        logic                            hit;
        logic                            last;
        logic [OUT_INDEX-1:0][DIM_W-1:0] index;
        logic [COUNT_W-1:0]              count;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/nonzero_index_compactor_core.sv
// A condition bit is registered in the input stage (cond_reg); its result is registered
// in the result stage (res_reg) as soon as that register is free.
// Throughput: one element per cycle while the result register is free, bounded by the
// combinational carry step of the position counter, which updates together with the
// true-element tally. Reset (rst_n, async, active low): positions and count to zero,
// num_dims and all extents to 1, both pipeline stages empty.
`default_nettype none

module nonzero_index_compactor_core
    import nic_pkg::*;
#(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    // condition stream
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cond_bit,
    // index results
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    hit,
    output logic      [DIM_W-1:0]   index_0,
    output logic      [DIM_W-1:0]   index_1,
    output logic      [DIM_W-1:0]   index_2,
    output logic      [DIM_W-1:0]   index_3,
    output logic      [COUNT_W-1:0] true_count,
    output logic                    last
);

    cfg_t    cfg;
    result_t res;
    result_t res_reg;

    // input stage
    logic in_valid_reg;
    logic in_valid_next;
    logic cond_reg;

    // result stage
    logic out_valid_reg;
    logic out_valid_next;

    logic out_free;   // result register may take a new value this cycle
    logic proc_fire;  // held element is processed and the counter steps
    logic in_take;

    nic_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nic_index_counter #(
        .MAX_DIMS    (MAX_DIMS),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cnt (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc_fire),
        .cond  (cond_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // The result register frees up when empty or when its transaction completes;
    // elements that produce no result still need this slot to advance, which keeps
    // results in order.
    assign out_free  = !out_valid_reg || !out_stall;
    assign proc_fire = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    assign in_valid_next  = in_take ? 1'b1 : (proc_fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = proc_fire ? res.emit : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cond_reg <= cond_bit;
        end
        if (proc_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = res_reg.hit;
    assign index_0    = res_reg.index[0];
    assign index_1    = res_reg.index[1];
    assign index_2    = res_reg.index[2];
    assign index_3    = res_reg.index[3];
    assign true_count = res_reg.count;
    assign last       = res_reg.last;

endmodule

`default_nettype wire

>>> hw/rtl/nic_cfg_regs.sv
// APB register bank holding dimension count and extents.
`default_nettype none

module nic_cfg_regs
    import nic_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_NUM_DIMS:   cfg_next.num_dims    = pwdata[ND_W-1:0];
                REG_DIM_SIZE_0: cfg_next.dim_size[0] = pwdata[DIM_W-1:0];
                REG_DIM_SIZE_1: cfg_next.dim_size[1] = pwdata[DIM_W-1:0];
                REG_DIM_SIZE_2: cfg_next.dim_size[2] = pwdata[DIM_W-1:0];
                REG_DIM_SIZE_3: cfg_next.dim_size[3] = pwdata[DIM_W-1:0];
                default:        cfg_next = cfg_reg;  // unmapped: ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dims <= ND_W'(1);
            for (int i = 0; i < NUM_SIZE_REGS; i++)
            begin
                cfg_reg.dim_size[i] <= DIM_W'(1);
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_NUM_DIMS:   prdata = DATA_W'(cfg_reg.num_dims);
            REG_DIM_SIZE_0: prdata = DATA_W'(cfg_reg.dim_size[0]);
            REG_DIM_SIZE_1: prdata = DATA_W'(cfg_reg.dim_size[1]);
            REG_DIM_SIZE_2: prdata = DATA_W'(cfg_reg.dim_size[2]);
            REG_DIM_SIZE_3: prdata = DATA_W'(cfg_reg.dim_size[3]);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/nic_index_counter.sv
// Multi-dimensional position counter with carry, true-element tally and result forming.
`default_nettype none

module nic_index_counter
    import nic_pkg::*;
#(
    parameter int MAX_DIMS    = MAX_DIMS_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic cond,
    input  wire cfg_t cfg,
    output result_t   res
);

    localparam int CW = (INDEX_WIDTH > DIM_W) ? INDEX_WIDTH : DIM_W;

    logic [INDEX_WIDTH-1:0] pos_reg  [MAX_DIMS];
    logic [INDEX_WIDTH-1:0] pos_next [MAX_DIMS];
    logic [CW-1:0]          pos_ext  [MAX_DIMS];
    logic [DIM_W-1:0]       lim      [MAX_DIMS];
    logic [COUNT_W-1:0]     count_reg;
    logic [COUNT_W-1:0]     count_next;
    logic [COUNT_W-1:0]     count_inc;
    logic [MAX_DIMS-1:0]    in_use;
    logic [MAX_DIMS-1:0]    at_end;
    logic [MAX_DIMS-1:0]    carry;
    logic                   last;

    // per-dimension decode: last coordinate, in-use flag, end-of-row flag
    for (genvar d = 0; d < MAX_DIMS; d++)
    begin : g_dim
        if (d < NUM_SIZE_REGS)
        begin : g_reg
            assign lim[d] = (cfg.dim_size[d] == '0) ? '0 : cfg.dim_size[d] - DIM_W'(1);
        end
        else
        begin : g_one
            assign lim[d] = '0;  // no register: extent 1
        end
        assign in_use[d]  = (d == 0) || (32'(cfg.num_dims) > d);
        assign pos_ext[d] = CW'(pos_reg[d]);
        assign at_end[d]  = pos_ext[d] >= CW'(lim[d]);
    end

    // carry ripples from the innermost dimension outward
    always_comb
    begin
        carry[MAX_DIMS-1] = 1'b1;
        for (int d = MAX_DIMS - 2; d >= 0; d--)
        begin
            carry[d] = carry[d+1] && (!in_use[d+1] || at_end[d+1]);
        end
        last = carry[0] && at_end[0];
    end

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (last)
                pos_next[d] = '0;
            else if (in_use[d] && carry[d])
                pos_next[d] = at_end[d] ? '0 : pos_reg[d] + INDEX_WIDTH'(1);
            else
                pos_next[d] = pos_reg[d];
        end
    end

    assign count_inc  = (cond && (count_reg != '1)) ? count_reg + COUNT_W'(1) : count_reg;
    assign count_next = last ? '0 : count_inc;

    assign res.emit  = cond || last;
    assign res.hit   = cond;
    assign res.last  = last;
    assign res.count = count_inc;

    for (genvar k = 0; k < OUT_INDEX; k++)
    begin : g_out
        if (k < MAX_DIMS)
        begin : g_live
            assign res.index[k] = (cond && in_use[k]) ? pos_ext[k][DIM_W-1:0] : '0;
        end
        else
        begin : g_none
            assign res.index[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                pos_reg[d] <= '0;
            end
            count_reg <= '0;
        end
        else if (step)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                pos_reg[d] <= pos_next[d];
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/nic_checker.sv
// Port-level checks for the nonzero index compactor and their bind.
`default_nettype none

module nic_checker
    import nic_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic               hit,
    input wire logic [DIM_W-1:0]   index_0,
    input wire logic [DIM_W-1:0]   index_1,
    input wire logic [DIM_W-1:0]   index_2,
    input wire logic [DIM_W-1:0]   index_3,
    input wire logic [COUNT_W-1:0] true_count,
    input wire logic               last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(hit) && $stable(last)
            && $stable(index_0) && $stable(index_1) && $stable(index_2)
            && $stable(index_3) && $stable(true_count))
        else $error("result changed while stalled");

    // every result is a true element or the end of the tensor
    a_emit_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hit || last)
        else $error("result with neither hit nor last");

    // end-of-tensor result for a false element carries no coordinates
    a_last_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last && !hit |->
            index_0 == '0 && index_1 == '0 && index_2 == '0 && index_3 == '0)
        else $error("nonzero index on final false element");

    // a hit is always counted
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> true_count != '0)
        else $error("hit with zero count");

    // input stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

endmodule

bind nonzero_index_compactor_core nic_checker u_nic_checker (.*);

`default_nettype wire

>>> dv/nic_result_checker.sv
// Checker for the nonzero index compactor: watches both channels and the APB port,
// predicts the index results and compares them.
`default_nettype none

module nic_result_checker
    import nic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    input  wire logic [DATA_W-1:0]  prdata,
    input  wire logic               pready,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               cond_bit,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic               hit,
    input  wire logic [DIM_W-1:0]   index_0,
    input  wire logic [DIM_W-1:0]   index_1,
    input  wire logic [DIM_W-1:0]   index_2,
    input  wire logic [DIM_W-1:0]   index_3,
    input  wire logic [COUNT_W-1:0] true_count,
    input  wire logic               last,
    output int                      fail_count,
    output int                      pending,
    output int                      results_seen
);

    localparam int SZ_IDX_W = $clog2(NUM_SIZE_REGS);

    // shadow registers and tensor walk state
    logic [ND_W-1:0]    nd_reg;
    logic [DIM_W-1:0]   extent_reg [NUM_SIZE_REGS];
    logic [DIM_W-1:0]   coord      [MAX_DIMS_DEF];
    logic [COUNT_W-1:0] tally;

    result_t            index_tuples_q[$];
    result_t            head;
    logic [REG_IDX_W-1:0] apb_idx;
    logic [SZ_IDX_W-1:0]  ext_idx;
    logic [DATA_W-1:0]  readback;

    function automatic int dims_used();
        if (nd_reg == '0)
            return 1;
        if (nd_reg > MAX_DIMS_DEF)
            return MAX_DIMS_DEF;
        return int'(nd_reg);
    endfunction

    // extent 0 counts as 1; a coordinate past the end also counts as at the end
    function automatic logic dim_at_end(input int d);
        logic [DIM_W-1:0] ext;
        ext = extent_reg[d];
        if (ext == '0)
            ext = DIM_W'(1);
        return coord[d] >= ext - 1'b1;
    endfunction

    task automatic step_element(input logic cond);
        int      nd;
        int      d;
        logic    final_elem;
        logic    carry;
        result_t r;
        nd = dims_used();
        final_elem = 1'b1;
        for (d = 0; d < nd; d++)
            if (!dim_at_end(d))
                final_elem = 1'b0;
        if (cond && tally != '1)
            tally = tally + 1'b1;
        if (cond || final_elem)
        begin
            r = '0;
            r.emit  = 1'b1;
            r.hit   = cond;
            r.last  = final_elem;
            r.count = tally;
            if (cond)
                for (d = 0; d < nd; d++)
                    r.index[d] = coord[d];
            index_tuples_q.push_back(r);
        end
        if (final_elem)
        begin
            for (d = 0; d < MAX_DIMS_DEF; d++)
                coord[d] = '0;
            tally = '0;
        end
        else
        begin
            carry = 1'b1;
            for (d = nd - 1; d >= 0; d--)
                if (carry)
                begin
                    if (dim_at_end(d))
                        coord[d] = '0;
                    else
                    begin
                        coord[d] = coord[d] + 1'b1;
                        carry = 1'b0;
                    end
                end
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_reg = ND_W'(1);
            for (int k = 0; k < NUM_SIZE_REGS; k++)
                extent_reg[k] = DIM_W'(1);
            for (int k = 0; k < MAX_DIMS_DEF; k++)
                coord[k] = '0;
            tally = '0;
            index_tuples_q.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
        end
        else
        begin
            apb_idx = paddr[ADDR_W-1:2];
            ext_idx = SZ_IDX_W'(apb_idx - REG_DIM_SIZE_0);
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (apb_idx)
                        REG_NUM_DIMS:
                            nd_reg = pwdata[ND_W-1:0];
                        REG_DIM_SIZE_0, REG_DIM_SIZE_1, REG_DIM_SIZE_2, REG_DIM_SIZE_3:
                            extent_reg[ext_idx] = pwdata[DIM_W-1:0];
                        default:
                            ;
                    endcase
                end
                else if (apb_idx <= REG_DIM_SIZE_3)
                begin
                    readback = '0;
                    if (apb_idx == REG_NUM_DIMS)
                        readback[ND_W-1:0] = nd_reg;
                    else
                        readback[DIM_W-1:0] = extent_reg[ext_idx];
                    check_field("prdata", readback, prdata);
                end
            end

            // drain before fill: a result never stems from a same-edge transaction
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (index_tuples_q.size() == 0)
                begin
                    $error("index result with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    head = index_tuples_q.pop_front();
                    check_field("hit", DATA_W'(head.hit), DATA_W'(hit));
                    check_field("index_0", DATA_W'(head.index[0]), DATA_W'(index_0));
                    check_field("index_1", DATA_W'(head.index[1]), DATA_W'(index_1));
                    check_field("index_2", DATA_W'(head.index[2]), DATA_W'(index_2));
                    check_field("index_3", DATA_W'(head.index[3]), DATA_W'(index_3));
                    check_field("true_count", DATA_W'(head.count), DATA_W'(true_count));
                    check_field("last", DATA_W'(head.last), DATA_W'(last));
                end
            end

            if (in_valid && !in_stall)
                step_element(cond_bit);

            pending = index_tuples_q.size();
        end
    end

endmodule

`default_nettype wire

>>> dv/nonzero_index_compactor_core_tb.sv
// Testbench top for the nonzero index compactor: clock, reset, stimulus and verdict.
`default_nettype none

module nonzero_index_compactor_core_tb
    import nic_pkg::*;
();

    localparam int ITEM_TARGET   = 820;      // random condition bits, roughly
    localparam int HOLD_CYCLES   = 120;      // receiver hold-off for the back-pressure run
    localparam int PRESSURE_ITER = 2;        // random setting at which the hold-off happens
    localparam int DRAIN_CYCLES  = 4;        // margin for a false element still in the pipe
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int LONG_EXTENT   = 65535;    // widest extent
    localparam int LONG_RUN      = 300;      // elements walked along it, past the low byte

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic               cond_bit;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic [DIM_W-1:0]   index_0;
    logic [DIM_W-1:0]   index_1;
    logic [DIM_W-1:0]   index_2;
    logic [DIM_W-1:0]   index_3;
    logic [COUNT_W-1:0] true_count;
    logic               last;

    int fail_count;
    int pending;
    int results_seen;

    int items_sent  = 0;
    int configs     = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int cycles      = 0;
    bit calm        = 1'b0;   // no gaps and no random stalls while set

    nonzero_index_compactor_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cond_bit   (cond_bit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .index_0    (index_0),
        .index_1    (index_1),
        .index_2    (index_2),
        .index_3    (index_3),
        .true_count (true_count),
        .last       (last)
    );

    nic_result_checker results_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cond_bit     (cond_bit),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .index_0      (index_0),
        .index_1      (index_1),
        .index_2      (index_2),
        .index_3      (index_3),
        .true_count   (true_count),
        .last         (last),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results outstanding", cycles, pending);
        $display("TB_ERROR");
        $finish;
    end

    // Idle length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // True-element density in percent: empty, full, half or anything between.
    function automatic int pick_density();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 100;
            2: return 50;
            default: return $urandom_range(5, 95);
        endcase
    endfunction

    // Receiver side. A hold-off request keeps out_stall high for a long stretch
    // counted here, independent of what the sender does meanwhile.
    initial
    begin
        int left;
        left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_served != hold_asked)
            begin
                hold_served = hold_asked;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (left > 0)
            begin
                out_stall <= 1'b1;
                left--;
            end
            else
            begin
                out_stall <= 1'b0;
                left = pick_gap();
            end
        end
    end

    // One condition-bit transaction. Drives at the falling edge, waits for the
    // accepting rising edge. Valid is left high so back-to-back items need no
    // second assignment in the same step.
    task automatic send_cond(input logic b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            cond_bit <= 1'($urandom_range(0, 1));   // payload is noise while idle
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cond_bit <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // APB write: setup cycle, then access cycle; the register takes it at the
    // rising edge inside the access cycle.
    task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        in_valid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b1;
        paddr    <= {idx, 2'b00};
        pwdata   <= value;
        @(negedge clk);
        penable  <= 1'b1;
        @(negedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
    endtask

    // APB read; the checker compares prdata with its shadow copy.
    task automatic reg_read(input logic [REG_IDX_W-1:0] idx);
        @(negedge clk);
        in_valid <= 1'b0;
        psel     <= 1'b1;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= {idx, 2'b00};
        @(negedge clk);
        penable  <= 1'b1;
        @(negedge clk);
        psel     <= 1'b0;
        penable  <= 1'b0;
    endtask

    // Block goes idle: every predicted result seen, then DRAIN_CYCLES more for a
    // false element still in the pipe (it gives no result to wait on).
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // New setting, written only once idle. Half the time the unused upper
    // bits of pwdata carry junk, which the registers must drop.
    task automatic apply_setting(input logic [31:0] nd, input logic [31:0] e0,
                                 input logic [31:0] e1, input logic [31:0] e2,
                                 input logic [31:0] e3);
        logic [DATA_W-1:0] junk;
        settle();
        junk = $urandom_range(0, 1) ? $urandom : '0;
        reg_write(REG_NUM_DIMS,   {junk[DATA_W-1:ND_W],  nd[ND_W-1:0]});
        reg_write(REG_DIM_SIZE_0, {junk[DATA_W-1:DIM_W], e0[DIM_W-1:0]});
        reg_write(REG_DIM_SIZE_1, {junk[DATA_W-1:DIM_W], e1[DIM_W-1:0]});
        reg_write(REG_DIM_SIZE_2, {junk[DATA_W-1:DIM_W], e2[DIM_W-1:0]});
        reg_write(REG_DIM_SIZE_3, {junk[DATA_W-1:DIM_W], e3[DIM_W-1:0]});
        configs++;
    endtask

    initial
    begin
        int ndsel;
        int eff;
        int total;
        int shape;
        int dens;
        int reps;
        int iter;
        int ext [NUM_SIZE_REGS];

        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        cond_bit = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed ----------------
        // Reset values read back, then the reset shape: one element per tensor,
        // so every transaction is final (a true one and a false one).
        for (int i = int'(REG_NUM_DIMS); i <= int'(REG_DIM_SIZE_3); i++)
            reg_read(REG_IDX_W'(i));
        send_cond(1'b1);
        send_cond(1'b0);

        // 2x3 tensor: carry into dimension 0, final element false.
        apply_setting(2, 2, 3, 1, 1);
        send_cond(1'b1); send_cond(1'b0); send_cond(1'b0);
        send_cond(1'b1); send_cond(1'b1); send_cond(1'b0);

        // num_dims of zero behaves as one dimension.
        apply_setting(0, 3, 1, 1, 1);
        send_cond(1'b0); send_cond(1'b1); send_cond(1'b1);

        // num_dims above the maximum clamps; extent zero behaves as one.
        apply_setting((1 << ND_W) - 1, 0, 2, 1, 2);
        repeat (4) send_cond(1'b1);

        // Extent shrunk mid-tensor below the current coordinate: next element
        // is taken as final.
        apply_setting(1, 5, 1, 1, 1);
        send_cond(1'b1); send_cond(1'b0); send_cond(1'b1);
        apply_setting(1, 2, 1, 1, 1);
        send_cond(1'b0);

        // Dimension dropped mid-tensor: its coordinate reads as 0 and is
        // cleared when the tensor ends.
        apply_setting(2, 3, 3, 1, 1);
        send_cond(1'b0); send_cond(1'b0); send_cond(1'b1); send_cond(1'b1);
        apply_setting(1, 3, 3, 1, 1);
        send_cond(1'b1); send_cond(1'b0);

        // Addresses past the last register must not disturb anything.
        settle();
        for (int i = int'(REG_DIM_SIZE_3) + 1; i < (1 << REG_IDX_W); i++)
            reg_write(REG_IDX_W'(i), $urandom);
        for (int i = int'(REG_NUM_DIMS); i <= int'(REG_DIM_SIZE_3); i++)
            reg_read(REG_IDX_W'(i));

        // ---------------- random ----------------
        // Mostly whole tensors with random content; some cut short so the next
        // setting lands mid-tensor, some pure noise.
        iter = 0;
        while (items_sent < ITEM_TARGET)
        begin
            ndsel = ($urandom_range(0, 99) < 85) ? $urandom_range(1, MAX_DIMS_DEF)
                                                 : $urandom_range(0, (1 << ND_W) - 1);
            eff = (ndsel == 0) ? 1 : ((ndsel > MAX_DIMS_DEF) ? MAX_DIMS_DEF : ndsel);
            total = 1;
            for (int d = 0; d < NUM_SIZE_REGS; d++)
            begin
                shape = $urandom_range(0, 99);
                if (d < eff)
                begin
                    ext[d] = (shape < 8) ? 0
                           : $urandom_range(1, (eff == 1 && shape > 85) ? 64 : 4);
                    total = total * ((ext[d] == 0) ? 1 : ext[d]);
                end
                else
                    // unused extents take the full range, the widest included
                    ext[d] = (shape < 20) ? LONG_EXTENT : $urandom_range(0, LONG_EXTENT);
            end

            if (iter == PRESSURE_ITER)
            begin
                // Every element true while the receiver holds off: results back
                // up and the block has to stall its input.
                apply_setting(1, 48, 1, 1, 1);
                calm = 1'b1;
                hold_asked++;
                repeat (48) send_cond(1'b1);
            end

            apply_setting(ndsel, ext[0], ext[1], ext[2], ext[3]);
            calm = ($urandom_range(0, 99) < 15);
            shape = $urandom_range(0, 99);
            if (shape < 80)
            begin
                reps = $urandom_range(1, 3);
                repeat (reps)
                begin
                    dens = pick_density();
                    repeat (total) send_cond($urandom_range(0, 99) < dens);
                end
            end
            else if (shape < 90)
            begin
                dens = pick_density();
                repeat ($urandom_range(1, total)) send_cond($urandom_range(0, 99) < dens);
            end
            else
                repeat ($urandom_range(1, 20)) send_cond($urandom_range(0, 1));

            if ($urandom_range(0, 9) == 0)
                reg_read(REG_IDX_W'($urandom_range(REG_NUM_DIMS, REG_DIM_SIZE_3)));
            iter++;
        end

        // ---------------- wide extent ----------------
        // Widest extent on the innermost dimension, sparse trues; the walk is
        // left mid-tensor once the coordinate has carried past its low byte.
        calm = 1'b1;
        apply_setting(MAX_DIMS_DEF, 1, 1, 1, LONG_EXTENT);
        for (int i = 0; i < LONG_RUN; i++)
            send_cond((i == LONG_RUN - 1) || ($urandom_range(0, 999) < 10));
        calm = 1'b0;
        settle();
        for (int i = int'(REG_NUM_DIMS); i <= int'(REG_DIM_SIZE_3); i++)
            reg_read(REG_IDX_W'(i));

        settle();
        $display("Sent %0d condition bits under %0d register settings, including a wide extent",
                 items_sent, configs);
        $display("and a receiver hold-off; %0d index results checked in %0d cycles",
                 results_seen, cycles);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> nonzero_index_compactor_core.f
hw/rtl/nic_pkg.sv
hw/rtl/nic_cfg_regs.sv
hw/rtl/nic_index_counter.sv
hw/rtl/nonzero_index_compactor_core.sv
hw/rtl/nic_checker.sv
dv/nic_result_checker.sv
dv/nonzero_index_compactor_core_tb.sv
